[src/qfu_pkg.sv]
// Package: types, character codes and sizes shared by the quoted field unescaper.
package qfu_pkg;

    // Scan modes of the field decoder
    typedef enum logic [2:0] {
        MODE_IDLE   = 3'd0,
        MODE_BARE   = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_ESC    = 3'd3,
        MODE_OCT1   = 3'd4,
        MODE_OCT2   = 3'd5
    } t_mode;

    // How a field ended
    typedef enum logic [1:0] {
        END_QUOTE  = 2'd0,
        END_NUL    = 2'd1,
        END_SPACE  = 2'd2,
        END_BUFFER = 2'd3
    } t_end_kind;

    // Class of a byte inside a quoted string
    typedef enum logic [1:0] {
        SC_NUL    = 2'd0,
        SC_QUOTE  = 2'd1,
        SC_BSLASH = 2'd2,
        SC_PLAIN  = 2'd3
    } t_sclass;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    localparam int OCT_W   = 6;
    localparam int QDEPTH  = 4;
    localparam int QIDX_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // One result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       field_end;
        t_end_kind  end_kind;
        logic       was_quoted;
    } t_result;

    // Results written into the result queue in one cycle (zero to two)
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
    } t_push;

    // Decoder verdict for one byte
    typedef struct packed {
        t_mode            mode;
        logic [OCT_W-1:0] oct;
        t_push            push;
    } t_dec;

    // Result queue status
    typedef struct packed {
        logic              room;
        logic [QCNT_W-1:0] count;
    } t_q_stat;

endpackage

[src/qfu_in_if.sv]
// Interface: input byte channel of the quoted field unescaper.
interface qfu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       buffer_last;

    modport source (output valid, output in_byte, output buffer_last, input ready);
    modport sink   (input valid, input in_byte, input buffer_last, output ready);
endinterface

[src/qfu_out_if.sv]
// Interface: result channel of the quoted field unescaper.
interface qfu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic [1:0] end_kind;
    logic       was_quoted;

    modport source (output valid, output out_byte, output byte_valid, output field_end,
                    output end_kind, output was_quoted, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input field_end,
                    input end_kind, input was_quoted, output ready);
endinterface

[src/qfu_decode.sv]
// Module: per-byte decoder, next scan state and up to two results.
module qfu_decode
    import qfu_pkg::*;
(
    input  t_mode            i_mode,
    input  logic [OCT_W-1:0] i_oct,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output t_dec             o_dec
);

    function automatic logic is_ws(input logic [7:0] b);
        return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
    endfunction

    function automatic logic is_oct(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_SEVEN);
    endfunction

    function automatic t_sclass sclass(input logic [7:0] b);
        t_sclass c;
        if (b == CH_NUL)         c = SC_NUL;
        else if (b == CH_QUOTE)  c = SC_QUOTE;
        else if (b == CH_BSLASH) c = SC_BSLASH;
        else                     c = SC_PLAIN;
        return c;
    endfunction

    logic             e0, e1, cl, quoted, fin_close;
    logic [7:0]       e0_byte, e1_byte;
    t_end_kind        cl_kind, fin_kind;
    t_mode            mode_pre;
    logic [OCT_W-1:0] oct_pre;

    // Events of this byte: emits, closing, provisional mode
    always_comb begin
        e0       = 1'b0;
        e1       = 1'b0;
        e0_byte  = '0;
        e1_byte  = '0;
        cl       = 1'b0;
        cl_kind  = END_QUOTE;
        mode_pre = i_mode;
        oct_pre  = i_oct;
        quoted   = 1'b1;
        unique case (i_mode) inside
            MODE_BARE: begin
                quoted = 1'b0;
                if (i_byte == CH_NUL) begin
                    cl = 1'b1; cl_kind = END_NUL;
                end else if (is_ws(i_byte)) begin
                    cl = 1'b1; cl_kind = END_SPACE;
                end else begin
                    e0 = 1'b1; e0_byte = i_byte;
                end
            end
            MODE_QUOTED: begin
                unique case (sclass(i_byte))
                    SC_NUL:    begin cl = 1'b1; cl_kind = END_NUL; end
                    SC_QUOTE:  begin cl = 1'b1; cl_kind = END_QUOTE; end
                    SC_BSLASH: mode_pre = MODE_ESC;
                    default:   begin e0 = 1'b1; e0_byte = i_byte; end
                endcase
            end
            MODE_ESC: begin
                mode_pre = MODE_QUOTED;
                if (i_byte == CH_NUL) begin
                    cl = 1'b1; cl_kind = END_NUL;
                end else if (i_byte == CH_QUOTE) begin
                    cl = 1'b1; cl_kind = END_QUOTE;
                end else if (i_byte == CH_N) begin
                    e0 = 1'b1; e0_byte = CH_LF;
                end else if (i_byte == CH_R) begin
                    e0 = 1'b1; e0_byte = CH_CR;
                end else if (i_byte == CH_T) begin
                    e0 = 1'b1; e0_byte = CH_TAB;
                end else if (is_oct(i_byte)) begin
                    // digit value is the low three bits of '0'..'7'
                    oct_pre  = OCT_W'(i_byte[2:0]);
                    mode_pre = MODE_OCT1;
                end else begin
                    e0 = 1'b1; e0_byte = i_byte;
                end
            end
            MODE_OCT1, MODE_OCT2: begin
                if (is_oct(i_byte)) begin
                    if (i_mode == MODE_OCT1) begin
                        oct_pre  = {i_oct[2:0], i_byte[2:0]};
                        mode_pre = MODE_OCT2;
                    end else begin
                        e0       = 1'b1;
                        e0_byte  = {i_oct[4:0], i_byte[2:0]};
                        oct_pre  = '0;
                        mode_pre = MODE_QUOTED;
                    end
                end else begin
                    // flush gathered digits, then treat the byte as a string byte
                    e0       = 1'b1;
                    e0_byte  = 8'(i_oct);
                    oct_pre  = '0;
                    mode_pre = MODE_QUOTED;
                    unique case (sclass(i_byte))
                        SC_NUL:    begin cl = 1'b1; cl_kind = END_NUL; end
                        SC_QUOTE:  begin cl = 1'b1; cl_kind = END_QUOTE; end
                        SC_BSLASH: mode_pre = MODE_ESC;
                        default:   begin e1 = 1'b1; e1_byte = i_byte; end
                    endcase
                end
            end
            default: begin
                oct_pre = '0;
                if (i_byte == CH_QUOTE) begin
                    mode_pre = MODE_QUOTED;
                end else begin
                    mode_pre = MODE_BARE;
                    quoted   = 1'b0;
                    if (i_byte == CH_NUL) begin
                        cl = 1'b1; cl_kind = END_NUL;
                    end else if (is_ws(i_byte)) begin
                        cl = 1'b1; cl_kind = END_SPACE;
                    end else begin
                        e0 = 1'b1; e0_byte = i_byte;
                    end
                end
            end
        endcase
    end

    assign fin_close = cl || (i_last && (mode_pre != MODE_IDLE));
    assign fin_kind  = cl ? cl_kind : END_BUFFER;

    // Next state and results
    always_comb begin
        o_dec.mode = fin_close ? MODE_IDLE : mode_pre;
        o_dec.oct  = fin_close ? '0 : oct_pre;
        o_dec.push.r0.out_byte   = e0_byte;
        o_dec.push.r0.byte_valid = e0;
        o_dec.push.r0.field_end  = fin_close && !e1;
        o_dec.push.r0.end_kind   = (fin_close && !e1) ? fin_kind : END_QUOTE;
        o_dec.push.r0.was_quoted = quoted;
        o_dec.push.r1.out_byte   = e1_byte;
        o_dec.push.r1.byte_valid = e1;
        o_dec.push.r1.field_end  = fin_close;
        o_dec.push.r1.end_kind   = fin_close ? fin_kind : END_QUOTE;
        o_dec.push.r1.was_quoted = quoted;
        if (e1)             o_dec.push.count = 2'd2;
        else if (e0)        o_dec.push.count = 2'd1;
        else if (fin_close) o_dec.push.count = 2'd1;
        else                o_dec.push.count = 2'd0;
    end

endmodule

[src/qfu_result_queue.sv]
// Module: small result queue, up to two writes and one read per cycle.
module qfu_result_queue
    import qfu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output t_q_stat     o_stat,
    qfu_out_if.source   o_out
);

    t_result           r_q [QDEPTH];
    logic [QIDX_W-1:0] r_head, r_tail, n_head, n_tail;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    logic              pop;
    t_result           head;

    assign pop  = o_out.valid && o_out.ready;
    assign head = r_q[r_head];

    always_comb begin
        n_head = pop ? QIDX_W'(r_head + 1'b1) : r_head;
        n_tail = QIDX_W'(r_tail + i_push.count);
        n_cnt  = QCNT_W'(r_cnt + i_push.count - pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_q[r_tail] <= i_push.r0;
        end
        if (i_push.count == 2'd2) begin
            r_q[QIDX_W'(r_tail + 1'b1)] <= i_push.r1;
        end
    end

    assign o_stat.room  = (r_cnt <= QCNT_W'(QDEPTH - 2));
    assign o_stat.count = r_cnt;

    assign o_out.valid      = (r_cnt != '0);
    assign o_out.out_byte   = head.out_byte;
    assign o_out.byte_valid = head.byte_valid;
    assign o_out.field_end  = head.field_end;
    assign o_out.end_kind   = head.end_kind;
    assign o_out.was_quoted = head.was_quoted;

endmodule

[src/quoted_field_unescaper.sv]
// Top level: quoted field unescaper, one raw byte in, decoded field bytes out.
//
//  channel  dir  payload                                        request
//  i_in     in   in_byte[7:0], buffer_last                      one raw byte
//  o_out    out  out_byte[7:0], byte_valid, field_end,
//                end_kind[1:0], was_quoted                      one result
//
// Takes one request per cycle while the queue has room. A byte is held in the input
// register, decoded into zero, one or two results that are written into the queue,
// which drives o_out. The 4-entry queue drains one result per cycle while o_out is
// ready; decoding holds while more than two results are queued. A byte with two
// results always follows two byte-less ones, so only o_out stalls hold input.
// Synchronous active-low reset returns the scanner to idle and empties the queue.
module quoted_field_unescaper
    import qfu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    qfu_in_if.sink    i_in,
    qfu_out_if.source o_out
);

    // Input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    // Scanner state
    t_mode            r_mode;
    logic [OCT_W-1:0] r_oct;

    t_dec             dec;
    t_push            push;
    t_q_stat          q_stat;
    logic             fire;

    // Decode the held request once the queue can take two results
    assign fire       = r_in_valid && q_stat.room;
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    // Payload needs no reset: advance only on an accepted request
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.in_byte;
            r_in_last <= i_in.buffer_last;
        end
    end

    qfu_decode u_decode (
        .i_mode (r_mode),
        .i_oct  (r_oct),
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .o_dec  (dec)
    );

    // Advance scanner state only on a decoded byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
            r_oct  <= '0;
        end else if (fire) begin
            r_mode <= dec.mode;
            r_oct  <= dec.oct;
        end
    end

    // Drop the results of a byte that is not decoded this cycle
    always_comb begin
        push       = dec.push;
        push.count = fire ? dec.push.count : 2'd0;
    end

    qfu_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_stat  (q_stat),
        .o_out   (o_out)
    );

    // The last byte of a buffer always leaves the scanner idle
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_in_last) |=> (r_mode == MODE_IDLE))
        else $error("scanner not idle after last byte of buffer");

    // Gathered octal digits exist only while an octal escape is open
    a_oct_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_mode != MODE_OCT1) && (r_mode != MODE_OCT2)) |-> (r_oct == '0))
        else $error("octal value left over outside an octal escape");

    // The result queue never overfills
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

endmodule
